@@ design/vrb_pkg.sv @@
// Package for the vector range and bearing block: payload and stage types,
// angle and polynomial constants, and the one-bit divider step.
// No dependencies; every other design file imports it.
package vrb_pkg;

    localparam int MAG_W   = 16;
    localparam int FRAC_W  = 14;
    localparam int Q_W     = FRAC_W + 1;
    localparam int RANGE_W = 15;
    localparam int ANG_W   = 16;
    localparam int SLOPE_W = 12;
    localparam int DQ_W    = 14;
    localparam int CORR_W  = 14;
    localparam int P_W     = 14;
    localparam int PROD1_W = DQ_W + SLOPE_W;
    localparam int PROD2_W = CORR_W + Q_W;
    localparam int DIV_STAGES = Q_W;

    localparam logic [ANG_W-1:0]   ANG_NORTH = 16'h0000;
    localparam logic [ANG_W-1:0]   ANG_EAST  = 16'h4000;
    localparam logic [ANG_W-1:0]   ANG_SOUTH = 16'h8000;
    localparam logic [ANG_W-1:0]   ANG_WEST  = 16'hC000;
    localparam logic [RANGE_W-1:0] RANGE_MAX = 15'h7FFF;

    localparam logic [CORR_W-1:0]  POLY_BASE  = 14'h2800;
    localparam logic [Q_W-1:0]     POLY_PIVOT = 15'h1333;
    localparam logic [SLOPE_W-1:0] POLY_SLOPE = 12'hB00;
    localparam logic [Q_W-1:0]     Q_ONE      = 15'h4000;

    typedef struct packed {
        logic signed [MAG_W-1:0] east_offset;
        logic signed [MAG_W-1:0] north_offset;
    } in_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_estimate;
        logic [ANG_W-1:0]   bearing;
    } out_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_estimate;
        logic               special;
        logic [ANG_W-1:0]   special_bearing;
        logic               x_pos;
        logic               y_pos;
        logic               east_major;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [MAG_W-1:0] mag_max;
        logic [MAG_W-1:0] mag_min;
    } prep_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   quo;
        logic [Q_W-1:0]   nlow;
        logic [MAG_W-1:0] den;
        side_t            side;
    } div_stage_t;

    typedef struct packed {
        logic [Q_W-1:0] quotient;
        side_t          side;
    } div_out_t;

    typedef struct packed {
        logic [P_W-1:0] angle_p;
        side_t          side;
    } poly_out_t;

    // One restoring division step: bring down the next numerator bit and
    // subtract the divisor when it fits.
    function automatic div_stage_t div_step(input div_stage_t cur);
        div_stage_t     nxt;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] den_ext;
        nxt     = cur;
        trial   = {cur.rem, cur.nlow[Q_W-1]};
        den_ext = {1'b0, cur.den};
        if (trial >= den_ext) begin
            nxt.rem = MAG_W'(trial - den_ext);
            nxt.quo = {cur.quo[Q_W-2:0], 1'b1};
        end else begin
            nxt.rem = trial[MAG_W-1:0];
            nxt.quo = {cur.quo[Q_W-2:0], 1'b0};
        end
        nxt.nlow = {cur.nlow[Q_W-2:0], 1'b0};
        return nxt;
    endfunction

endpackage

@@ design/vrb_prep.sv @@
// First pipeline stage: magnitudes, major axis, range estimate and the
// zero-axis bearings. Depends on vrb_pkg.
module vrb_prep (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vrb_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vrb_pkg::prep_t out_data
);
    import vrb_pkg::*;

    logic               valid_reg;
    prep_t              data_reg;
    prep_t              data_next;
    logic [MAG_W-1:0]   east_bits;
    logic [MAG_W-1:0]   north_bits;
    logic [MAG_W-1:0]   mag_e;
    logic [MAG_W-1:0]   mag_n;
    logic [MAG_W:0]     range_sum;
    logic               e_zero;
    logic               n_zero;

    always_comb begin
        east_bits  = in_data.east_offset;
        north_bits = in_data.north_offset;
        mag_e  = east_bits[MAG_W-1] ? (~east_bits + 16'd1) : east_bits;
        mag_n  = north_bits[MAG_W-1] ? (~north_bits + 16'd1) : north_bits;
        e_zero = (east_bits == '0);
        n_zero = (north_bits == '0);

        data_next.side.east_major = (mag_e > mag_n);
        if (mag_e > mag_n) begin
            data_next.mag_max = mag_e;
            data_next.mag_min = mag_n;
        end else begin
            data_next.mag_max = mag_n;
            data_next.mag_min = mag_e;
        end
        range_sum = {1'b0, data_next.mag_max} + {2'b00, data_next.mag_min[MAG_W-1:1]};
        if (range_sum > (MAG_W+1)'(RANGE_MAX)) begin
            data_next.side.range_estimate = RANGE_MAX;
        end else begin
            data_next.side.range_estimate = range_sum[RANGE_W-1:0];
        end

        data_next.side.x_pos = !east_bits[MAG_W-1];
        data_next.side.y_pos = !north_bits[MAG_W-1];
        if (e_zero) begin
            data_next.side.special = 1'b1;
            data_next.side.special_bearing =
                (!n_zero && !north_bits[MAG_W-1]) ? ANG_NORTH : ANG_SOUTH;
        end else if (n_zero) begin
            data_next.side.special = 1'b1;
            data_next.side.special_bearing = east_bits[MAG_W-1] ? ANG_WEST : ANG_EAST;
        end else begin
            data_next.side.special = 1'b0;
            data_next.side.special_bearing = ANG_NORTH;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/vrb_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, that forms the
// ratio of the minor to the major magnitude scaled by 2^14. Depends on vrb_pkg.
module vrb_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vrb_pkg::prep_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vrb_pkg::div_out_t out_data
);
    import vrb_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    div_stage_t            stage_reg [DIV_STAGES];
    div_stage_t            step_in   [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_in;
    logic [DIV_STAGES:0]   rdy;
    div_stage_t            first;

    always_comb begin
        first.rem  = {1'b0, in_data.mag_min[MAG_W-1:1]};
        first.quo  = '0;
        first.nlow = {in_data.mag_min[0], {(Q_W-1){1'b0}}};
        first.den  = in_data.mag_max;
        first.side = in_data.side;
    end

    always_comb begin
        rdy[DIV_STAGES] = out_ready;
        for (int i = DIV_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        step_in[0]  = first;
        valid_in[0] = in_valid;
        for (int i = 1; i < DIV_STAGES; i++) begin
            step_in[i]  = stage_reg[i-1];
            valid_in[i] = valid_reg[i-1];
        end
    end

    assign in_ready          = rdy[0];
    assign out_valid         = valid_reg[DIV_STAGES-1];
    assign out_data.quotient = stage_reg[DIV_STAGES-1].quo;
    assign out_data.side     = stage_reg[DIV_STAGES-1].side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (rdy[i] && valid_in[i]) begin
                stage_reg[i] <= div_step(step_in[i]);
            end
        end
    end

    // The quotient of the minor by the major magnitude never exceeds one.
    a_quo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[DIV_STAGES-1] && !stage_reg[DIV_STAGES-1].side.special
        |-> stage_reg[DIV_STAGES-1].quo <= Q_ONE)
        else $error("divider quotient above one");

    // A restoring remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && (stage_reg[0].den != '0)
        |-> stage_reg[0].rem < stage_reg[0].den)
        else $error("divider remainder not below divisor");

endmodule

@@ design/vrb_poly.sv @@
// Two multiplier stages for the quadratic octant correction of the ratio.
// Depends on vrb_pkg.
module vrb_poly (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrb_pkg::div_out_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vrb_pkg::poly_out_t out_data
);
    import vrb_pkg::*;

    logic               a_valid_reg;
    logic [PROD1_W-1:0] a_prod_reg;
    logic [PROD1_W-1:0] a_prod_next;
    logic [Q_W-1:0]     a_quo_reg;
    side_t              a_side_reg;
    logic               b_valid_reg;
    logic [PROD2_W-1:0] b_prod_reg;
    logic [PROD2_W-1:0] b_prod_next;
    side_t              b_side_reg;
    logic [DQ_W-1:0]    dq;
    logic [CORR_W-1:0]  corr;
    logic               a_ready;
    logic               b_ready;

    always_comb begin
        if (in_data.quotient >= POLY_PIVOT) begin
            dq = DQ_W'(in_data.quotient - POLY_PIVOT);
        end else begin
            dq = DQ_W'(POLY_PIVOT - in_data.quotient);
        end
        a_prod_next = PROD1_W'(dq) * PROD1_W'(POLY_SLOPE);
        corr        = POLY_BASE - CORR_W'(a_prod_reg[PROD1_W-1:FRAC_W]);
        b_prod_next = PROD2_W'(corr) * PROD2_W'(a_quo_reg);
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign out_valid        = b_valid_reg;
    assign out_data.angle_p = b_prod_reg[FRAC_W+P_W-1:FRAC_W];
    assign out_data.side    = b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_prod_reg <= a_prod_next;
            a_quo_reg  <= in_data.quotient;
            a_side_reg <= in_data.side;
        end
        if (b_ready && a_valid_reg) begin
            b_prod_reg <= b_prod_next;
            b_side_reg <= a_side_reg;
        end
    end

    // The octant angle never exceeds 8269, which fits its field, so the
    // product bits above the kept field are zero.
    a_prod_top: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_side_reg.special
        |-> b_prod_reg[PROD2_W-1:FRAC_W+P_W] == '0)
        else $error("octant angle product overflow");

endmodule

@@ design/vector_range_bearing.sv @@
// Range and bearing of a signed east/north offset. Each transfer in gives
// one transfer out: a range estimate (major magnitude plus half the minor,
// saturated at 32767) and a 16-bit bearing with north at 0 and east at
// 0x4000. The block takes one transfer per cycle unless m_ready holds it
// back, and each result passes nineteen register stages: one setup stage,
// fifteen divider stages (one quotient bit each), two multiplier stages
// and the output register that folds the octant angle into the full
// circle. Backpressure from m_ready stalls only the stages that hold
// data, so bubbles are squeezed out.
// Depends on vrb_pkg, vrb_prep, vrb_div and vrb_poly.
module vector_range_bearing (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vrb_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vrb_pkg::out_t m_data
);
    import vrb_pkg::*;

    logic      prep_valid;
    logic      prep_ready;
    prep_t     prep_data;
    logic      div_valid;
    logic      div_ready;
    div_out_t  div_data;
    logic      poly_valid;
    logic      poly_ready;
    poly_out_t poly_data;

    logic             m_valid_reg;
    out_t             out_reg;
    out_t             out_next;
    logic [ANG_W-1:0] p_ext;

    vrb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    vrb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    vrb_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    always_comb begin
        p_ext = ANG_W'(poly_data.angle_p);
        out_next.range_estimate = poly_data.side.range_estimate;
        if (poly_data.side.special) begin
            out_next.bearing = poly_data.side.special_bearing;
        end else if (poly_data.side.x_pos && poly_data.side.y_pos) begin
            out_next.bearing = poly_data.side.east_major ? (ANG_EAST - p_ext) : p_ext;
        end else if (poly_data.side.x_pos) begin
            out_next.bearing = poly_data.side.east_major ? (ANG_EAST + p_ext)
                                                         : (ANG_SOUTH - p_ext);
        end else if (poly_data.side.y_pos) begin
            out_next.bearing = poly_data.side.east_major ? (ANG_WEST + p_ext)
                                                         : (ANG_NORTH - p_ext);
        end else begin
            out_next.bearing = poly_data.side.east_major ? (ANG_WEST - p_ext)
                                                         : (ANG_SOUTH + p_ext);
        end
    end

    assign poly_ready = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (poly_ready) begin
            m_valid_reg <= poly_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (poly_ready && poly_valid) begin
            out_reg <= out_next;
        end
    end

    // With the output register empty, every stage behind it can move.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while output register empty");

    // A zero range only comes from the zero vector, which points south.
    a_zero_south: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_reg.range_estimate == '0) |-> out_reg.bearing == ANG_SOUTH)
        else $error("zero vector not reported as south");

endmodule

@@ tb/vector_range_bearing_tb.sv @@
// Self-checking testbench for vector_range_bearing: drives east/north offsets
// through valid/ready, predicts range and bearing, and checks each transfer out.
// Depends on vrb_pkg and the vector_range_bearing RTL.
`timescale 1ns / 1ps

module vector_range_bearing_tb;
    import vrb_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 350;
    localparam int SQUEEZE_ITEMS = 80;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    in_t  pending_offsets[$];
    out_t expected_fixes[$];
    out_t want;
    logic in_fire = 1'b0;
    int   quiet_cycles = 0;
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left = 0;
    int   corner_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};

    vector_range_bearing dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Range is major plus half minor; bearing folds an octant angle from the
    // quadratic fit of the minor/major ratio into the full circle.
    function automatic out_t fix_of(in_t v);
        int               x, y, ax, ay, major, minor, r;
        longint           q, dq, p;
        logic             east_major;
        logic [ANG_W-1:0] a;
        logic [ANG_W-1:0] p16;
        out_t             f;
        x = int'(v.east_offset);
        y = int'(v.north_offset);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        east_major = ax > ay;
        major = east_major ? ax : ay;
        minor = east_major ? ay : ax;
        r = major + (minor >>> 1);
        if (r > int'(RANGE_MAX)) begin
            r = int'(RANGE_MAX);
        end
        f.range_estimate = r[RANGE_W-1:0];
        if (x == 0) begin
            a = (y > 0) ? ANG_NORTH : ANG_SOUTH;
        end else if (y == 0) begin
            a = (x > 0) ? ANG_EAST : ANG_WEST;
        end else begin
            q = (longint'(minor) << FRAC_W) / major;
            dq = longint'(POLY_PIVOT) - q;
            if (dq < 0) begin
                dq = -dq;
            end
            p = ((longint'(POLY_BASE) - ((dq * longint'(POLY_SLOPE)) >>> FRAC_W)) * q)
                >>> FRAC_W;
            p16 = p[ANG_W-1:0];
            if (x > 0) begin
                if (y > 0) begin
                    a = east_major ? ANG_EAST - p16 : p16;
                end else begin
                    a = east_major ? ANG_EAST + p16 : ANG_SOUTH - p16;
                end
            end else begin
                if (y > 0) begin
                    a = east_major ? ANG_WEST + p16 : ANG_NORTH - p16;
                end else begin
                    a = east_major ? ANG_WEST - p16 : ANG_SOUTH + p16;
                end
            end
        end
        f.bearing = a;
        return f;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        errors++;
    endtask

    task automatic queue_offsets(int e, int n);
        in_t v;
        v.east_offset  = e[MAG_W-1:0];
        v.north_offset = n[MAG_W-1:0];
        pending_offsets.push_back(v);
    endtask

    task automatic queue_random(int count);
        int e, n, m;
        repeat (count) begin
            case ($urandom_range(0, 7))
                3: begin
                    e = int'($urandom_range(0, 32)) - 16;
                    n = int'($urandom_range(0, 32)) - 16;
                end
                4: begin
                    m = $urandom_range(1, 32767);
                    e = m;
                    n = m + int'($urandom_range(0, 4)) - 2;
                    if (n > 32767) begin
                        n = 32767;
                    end
                    if ($urandom_range(0, 1)) begin
                        e = -e;
                    end
                    if ($urandom_range(0, 1)) begin
                        n = -n;
                    end
                end
                5: begin
                    e = $urandom;
                    n = $urandom;
                    if ($urandom_range(0, 1)) begin
                        e = 0;
                    end else begin
                        n = 0;
                    end
                end
                6: begin
                    e = corner_vals[$urandom_range(0, 5)];
                    n = corner_vals[$urandom_range(0, 5)];
                end
                7: begin
                    e = $urandom_range(16384, 32767);
                    n = $urandom_range(16384, 32767);
                    if ($urandom_range(0, 1)) begin
                        e = -e;
                    end
                    if ($urandom_range(0, 1)) begin
                        n = -n;
                    end
                end
                default: begin
                    e = $urandom;
                    n = $urandom;
                end
            endcase
            queue_offsets(e, n);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_offsets.size() != 0 || s_valid || expected_fixes.size() != 0);
    endtask

    task automatic set_pace(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_offsets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_offsets.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_fixes.size() == 0) begin
                    report_mismatch("transfer out with nothing outstanding",
                                    int'(m_data), 0);
                end else begin
                    want = expected_fixes.pop_front();
                    if (m_data.range_estimate !== want.range_estimate) begin
                        report_mismatch("range_estimate", int'(m_data.range_estimate),
                                        int'(want.range_estimate));
                    end
                    if (m_data.bearing !== want.bearing) begin
                        report_mismatch("bearing", int'(m_data.bearing),
                                        int'(want.bearing));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_fixes.push_back(fix_of(s_data));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("vector_range_bearing: mismatch");
        $finish;
    end

    initial begin
        int i, e, n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_pace(0, 0);
        queue_offsets(0, 0);
        queue_offsets(0, 1);
        queue_offsets(0, -1);
        queue_offsets(1, 0);
        queue_offsets(-1, 0);
        queue_offsets(0, -32768);
        queue_offsets(-32768, 0);
        queue_offsets(0, 32767);
        queue_offsets(32767, 0);
        queue_offsets(32767, 32767);
        queue_offsets(-32768, -32768);
        queue_offsets(-32768, 32767);
        queue_offsets(100, 100);
        queue_offsets(-100, -100);
        for (i = 0; i < 8; i++) begin
            e = i[0] ? 5 : 3;
            n = i[0] ? 3 : 5;
            if (i[1]) begin
                e = -e;
            end
            if (i[2]) begin
                n = -n;
            end
            queue_offsets(e, n);
        end
        queue_offsets(1, 32767);
        queue_offsets(32767, -1);
        queue_offsets(-4915, 16384);
        wait_idle();

        set_pace(0, 0);
        queue_random(PHASE_ITEMS);
        wait_idle();

        set_pace(53, 0);
        queue_random(PHASE_ITEMS);
        wait_idle();

        set_pace(0, 53);
        queue_random(PHASE_ITEMS);
        wait_idle();

        set_pace(11, 11);
        queue_random(PHASE_ITEMS);
        wait_idle();

        // Receiver holds off long enough for the pipeline to fill and stall
        // the input while the sender keeps offering.
        set_pace(0, 0);
        holds_asked = holds_asked + 1;
        queue_random(SQUEEZE_ITEMS);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("vector_range_bearing: match");
        end else begin
            $display("vector_range_bearing: mismatch");
        end
        $finish;
    end

endmodule
